// ----- sv/qte_pkg.sv -----
package qte_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NORM_TOP      = 13;
  localparam int SC_W          = 15;   // scaled component, magnitude below 2^14
  localparam int PR_W          = 30;   // product of two scaled components
  localparam int MW            = 33;   // matrix entries and norm
  localparam int XW            = 36;   // CORDIC x/y datapath
  localparam int ZW            = 34;   // angle accumulator, 2^32 units per turn
  localparam int ANGLE_W       = 16;
  localparam int ANGLE_MAX     = 25736;
  localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);

  typedef enum logic {
    SEQ_ZYX = 1'b0,
    SEQ_ZYZ = 1'b1
  } seq_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_first;
    logic signed [ANGLE_W-1:0] angle_second;
    logic signed [ANGLE_W-1:0] angle_third;
    logic                      degenerate;
    logic                      zero_input;
  } euler_t;

  typedef struct packed {
    seq_t mode;
    logic zero;
    logic degen;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic signed [MW-1:0] y1;
    logic signed [MW-1:0] x1;
    logic signed [MW-1:0] oth2;
    logic signed [MW-1:0] y3;
    logic signed [MW-1:0] x3;
  } front_t;

  function automatic logic signed [ZW-1:0] atan_unit(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return signed'({{(ZW-32){1'b0}}, v});
  endfunction

endpackage

// ----- sv/qte_front.sv -----
module qte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  qte_pkg::quat_t     in_q,
  input  qte_pkg::seq_t      mode,
  output logic               out_valid,
  output logic [63:0]        out_op,
  output qte_pkg::front_t    out_side
);

  localparam int DW = qte_pkg::DATA_WIDTH;
  localparam int TW = $clog2(DW);
  localparam int SW = qte_pkg::SC_W;
  localparam int PW = qte_pkg::PR_W;
  localparam int MW = qte_pkg::MW;
  localparam int NT = qte_pkg::NORM_TOP;

  // Stage 1: input register.
  logic                 v1;
  logic signed [DW-1:0] q1 [4];
  qte_pkg::seq_t        mode1;

  // Stage 2: magnitudes and the largest of them.
  logic                 v2;
  logic [DW-1:0]        mag2 [4];
  logic                 neg2 [4];
  logic [DW-1:0]        max2;
  qte_pkg::seq_t        mode2;
  logic [DW-1:0]        mag2_next [4];
  logic [DW-1:0]        max2_next;

  // Stage 3: power-of-two scaling.
  logic                 v3;
  logic signed [SW-1:0] sc3 [4];
  logic                 zero3;
  qte_pkg::seq_t        mode3;
  logic signed [SW-1:0] sc3_next [4];

  // Stage 4: products.
  logic                 v4;
  logic signed [PW-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic                 zero4;
  qte_pkg::seq_t        mode4;

  // Stage 5: matrix entries scaled by the squared norm.
  logic                 v5;
  logic signed [MW-1:0] n2, m00, m02, m10, m12, m20, m21, m22;
  logic                 zero5;
  qte_pkg::seq_t        mode5;

  // Stage 6: root operands and atan2 operands.
  logic                 v6;
  logic [31:0]          a6, b6;
  qte_pkg::front_t      side6;
  logic signed [MW-1:0] sel5;
  logic signed [MW-1:0] a6_next, b6_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    q1[0] <= in_q.quat_w;
    q1[1] <= in_q.quat_x;
    q1[2] <= in_q.quat_y;
    q1[3] <= in_q.quat_z;
    mode1 <= mode;
  end

  always_comb begin
    max2_next = '0;
    for (int k = 0; k < 4; k++) begin
      mag2_next[k] = q1[k][DW-1] ? DW'(-q1[k]) : DW'(q1[k]);
      if (mag2_next[k] > max2_next) begin
        max2_next = mag2_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      mag2[k] <= mag2_next[k];
      neg2[k] <= q1[k][DW-1];
    end
    max2  <= max2_next;
    mode2 <= mode1;
  end

  always_comb begin
    logic [TW-1:0]        top;
    logic [DW+NT-1:0]     ext;
    logic [DW+NT-1:0]     shd;
    logic [SW-1:0]        mg;
    top = '0;
    ext = '0;
    shd = '0;
    mg  = '0;
    for (int i = 0; i < DW; i++) begin
      if (max2[i]) begin
        top = TW'(i);
      end
    end
    for (int k = 0; k < 4; k++) begin
      ext = {{NT{1'b0}}, mag2[k]};
      if (int'(top) >= NT) begin
        shd = ext >> (int'(top) - NT);
      end else begin
        shd = ext << (NT - int'(top));
      end
      mg = {1'b0, shd[SW-2:0]};
      sc3_next[k] = neg2[k] ? -signed'(mg) : signed'(mg);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sc3[k] <= sc3_next[k];
    end
    zero3 <= (max2 == '0);
    mode3 <= mode2;
  end

  always_ff @(posedge clk) begin
    ww <= PW'(sc3[0] * sc3[0]);
    xx <= PW'(sc3[1] * sc3[1]);
    yy <= PW'(sc3[2] * sc3[2]);
    zz <= PW'(sc3[3] * sc3[3]);
    wx <= PW'(sc3[0] * sc3[1]);
    wy <= PW'(sc3[0] * sc3[2]);
    wz <= PW'(sc3[0] * sc3[3]);
    xy <= PW'(sc3[1] * sc3[2]);
    xz <= PW'(sc3[1] * sc3[3]);
    yz <= PW'(sc3[2] * sc3[3]);
    zero4 <= zero3;
    mode4 <= mode3;
  end

  always_ff @(posedge clk) begin
    n2  <= MW'(ww) + MW'(xx) + MW'(yy) + MW'(zz);
    m00 <= MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
    m22 <= MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
    m02 <= (MW'(wy) + MW'(xz)) <<< 1;
    m10 <= (MW'(xy) + MW'(wz)) <<< 1;
    m12 <= (MW'(yz) - MW'(wx)) <<< 1;
    m20 <= (MW'(xz) - MW'(wy)) <<< 1;
    m21 <= (MW'(wx) + MW'(yz)) <<< 1;
    zero5 <= zero4;
    mode5 <= mode4;
  end

  // For ZYZ the root argument m02^2 + m12^2 equals n2^2 - m22^2, since a
  // column of the scaled rotation matrix has norm n2.
  always_comb begin
    sel5    = (mode5 == qte_pkg::SEQ_ZYZ) ? m22 : m20;
    a6_next = n2 - sel5;
    b6_next = n2 + sel5;
  end

  always_ff @(posedge clk) begin
    a6 <= a6_next[31:0];
    b6 <= b6_next[31:0];
    side6.flags.mode  <= mode5;
    side6.flags.zero  <= zero5;
    side6.flags.degen <= (mode5 == qte_pkg::SEQ_ZYZ) && (m02 == '0) && (m12 == '0);
    if (mode5 == qte_pkg::SEQ_ZYZ) begin
      side6.y1   <= -m12;
      side6.x1   <= -m02;
      side6.oth2 <= m22;
      side6.y3   <= -m21;
      side6.x3   <= m20;
    end else begin
      side6.y1   <= m10;
      side6.x1   <= m00;
      side6.oth2 <= -m20;
      side6.y3   <= m21;
      side6.x3   <= m22;
    end
  end

  always_ff @(posedge clk) begin
    out_op   <= {32'd0, a6} * {32'd0, b6};
    out_side <= side6;
  end

endmodule

// ----- sv/qte_sqrt.sv -----
module qte_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      in_op,
  input  qte_pkg::front_t  in_side,
  output logic             out_valid,
  output logic [31:0]      out_root,
  output qte_pkg::front_t  out_side
);

  localparam int SQ = 32;

  logic            vs    [SQ+1];
  logic [63:0]     ops   [SQ+1];
  logic [35:0]     rems  [SQ+1];
  logic [31:0]     roots [SQ+1];
  qte_pkg::front_t sides [SQ+1];

  assign vs[0]    = in_valid;
  assign ops[0]   = in_op;
  assign rems[0]  = '0;
  assign roots[0] = '0;
  assign sides[0] = in_side;

  // One result bit per stage: bring down two operand bits and try the
  // next odd number.
  for (genvar s = 0; s < SQ; s++) begin : g_stage
    logic [35:0] rem_sh;
    logic [35:0] trial;
    always_comb begin
      rem_sh = {rems[s][33:0], ops[s][63:62]};
      trial  = {2'b00, roots[s], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s+1] <= 1'b0;
      end else begin
        vs[s+1] <= vs[s];
      end
    end

    always_ff @(posedge clk) begin
      ops[s+1]   <= {ops[s][61:0], 2'b00};
      sides[s+1] <= sides[s];
      if (rem_sh >= trial) begin
        rems[s+1]  <= rem_sh - trial;
        roots[s+1] <= {roots[s][30:0], 1'b1};
      end else begin
        rems[s+1]  <= rem_sh;
        roots[s+1] <= {roots[s][30:0], 1'b0};
      end
    end
  end

  assign out_valid = vs[SQ];
  assign out_root  = roots[SQ];
  assign out_side  = sides[SQ];

endmodule

// ----- sv/qte_cordic.sv -----
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [qte_pkg::MW-1:0] in_y,
  input  logic signed [qte_pkg::MW-1:0] in_x,
  output logic                          out_valid,
  output logic signed [qte_pkg::ZW-1:0] out_z
);

  localparam int XW = qte_pkg::XW;
  localparam int ZW = qte_pkg::ZW;

  logic                 vs [STAGES+1];
  logic                 sp [STAGES+1];
  logic signed [XW-1:0] xs [STAGES+1];
  logic signed [XW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];

  logic signed [XW-1:0] ye, xe;
  logic signed [XW-1:0] x0_next, y0_next;
  logic signed [ZW-1:0] z0_next;
  logic                 sp0_next;

  // Axis cases resolve at once; the left half-plane is rotated by a
  // quarter turn so the iterations converge.
  always_comb begin
    ye = XW'(in_y);
    xe = XW'(in_x);
    x0_next  = xe;
    y0_next  = ye;
    z0_next  = '0;
    sp0_next = 1'b0;
    if (ye == '0) begin
      sp0_next = 1'b1;
      z0_next  = (xe < 0) ? qte_pkg::HALF_TURN : '0;
    end else if (xe == '0) begin
      sp0_next = 1'b1;
      z0_next  = (ye > 0) ? qte_pkg::QUARTER_TURN : -qte_pkg::QUARTER_TURN;
    end else if (xe < 0) begin
      if (ye > 0) begin
        x0_next = ye;
        y0_next = -xe;
        z0_next = qte_pkg::QUARTER_TURN;
      end else begin
        x0_next = -ye;
        y0_next = xe;
        z0_next = -qte_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= x0_next;
    ys[0] <= y0_next;
    zs[0] <= z0_next;
    sp[0] <= sp0_next;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    always_comb begin
      dx = ys[i] >>> i;
      dy = xs[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      sp[i+1] <= sp[i];
      if (sp[i]) begin
        xs[i+1] <= xs[i];
        ys[i+1] <= ys[i];
        zs[i+1] <= zs[i];
      end else if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + qte_pkg::atan_unit(i);
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - qte_pkg::atan_unit(i);
      end
    end
  end

  assign out_valid = vs[STAGES];
  assign out_z     = zs[STAGES];

endmodule

// ----- sv/qte_conv.sv -----
module qte_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [qte_pkg::ZW-1:0] in_z1,
  input  logic signed [qte_pkg::ZW-1:0] in_z2,
  input  logic signed [qte_pkg::ZW-1:0] in_z3,
  input  qte_pkg::flags_t               in_flags,
  output logic                          out_valid,
  output qte_pkg::euler_t               out_euler
);

  localparam int AW = qte_pkg::ANGLE_W;

  logic signed [qte_pkg::ZW-1:0] zin [3];
  logic                          va, vb;
  logic                          nega [3];
  logic [31:0]                   maga [3];
  logic                          negb [3];
  logic [63:0]                   prodb [3];
  qte_pkg::flags_t               fa, fb;
  logic signed [AW-1:0]          ang [3];

  assign zin[0] = in_z1;
  assign zin[1] = in_z2;
  assign zin[2] = in_z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  // The ZYZ second angle is the negated atan2.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      maga[l] <= (zin[l] < 0) ? 32'(-zin[l]) : 32'(zin[l]);
      if (l == 1 && in_flags.mode == qte_pkg::SEQ_ZYZ) begin
        nega[l] <= (zin[l] > 0);
      end else begin
        nega[l] <= (zin[l] < 0);
      end
    end
    fa <= in_flags;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      prodb[l] <= {32'd0, maga[l]} * qte_pkg::TWO_PI_Q29;
      negb[l]  <= nega[l];
    end
    fb <= fa;
  end

  always_comb begin
    logic [63:0] rnd;
    logic [15:0] mg;
    rnd = '0;
    mg  = '0;
    for (int l = 0; l < 3; l++) begin
      rnd = (prodb[l] + (64'd1 << 47)) >> 48;
      if (rnd > 64'(qte_pkg::ANGLE_MAX)) begin
        mg = 16'(qte_pkg::ANGLE_MAX);
      end else begin
        mg = rnd[15:0];
      end
      ang[l] = negb[l] ? -signed'(mg) : signed'(mg);
    end
  end

  always_ff @(posedge clk) begin
    if (fb.zero) begin
      out_euler <= '{angle_first: '0, angle_second: '0, angle_third: '0,
                     degenerate: 1'b0, zero_input: 1'b1};
    end else if (fb.degen) begin
      out_euler <= '{angle_first: '0, angle_second: ang[1], angle_third: '0,
                     degenerate: 1'b1, zero_input: 1'b0};
    end else begin
      out_euler <= '{angle_first: ang[0], angle_second: ang[1], angle_third: ang[2],
                     degenerate: 1'b0, zero_input: 1'b0};
    end
  end

endmodule

// ----- sv/quaternion_to_euler_top.sv -----
// Quaternion to Euler angle converter, ZYX or ZYZ sequence.
// An item is a quaternion on quat, taken at a rising edge where start is
// high and busy is low. busy stays low, so an item may be given in every
// cycle. Each result appears on euler for exactly one cycle with done high;
// the receiver must take it then, as the block cannot hold it.
// The sequence register is written over cfg_valid/cfg_ready/cfg_data, with
// cfg_ready always high; write it only when no item is in flight.
// From start to done an item passes the scaling and the scaled rotation
// matrix, the bit-per-stage square root, the three parallel atan2 lanes and
// the conversion to radians times 8192. Throughput is one item per cycle,
// set by the fully pipelined root and CORDIC stages.
// Reset clears all valid bits and selects ZYX; items in flight are dropped.
module quaternion_to_euler_top #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  qte_pkg::quat_t  quat,
  output logic            done,
  output qte_pkg::euler_t euler,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);

  localparam int MW = qte_pkg::MW;
  localparam int ZW = qte_pkg::ZW;

  qte_pkg::seq_t   mode;
  logic            fr_valid;
  logic [63:0]     fr_op;
  qte_pkg::front_t fr_side;
  logic            sq_valid;
  logic [31:0]     sq_root;
  qte_pkg::front_t sq_side;
  logic signed [MW-1:0] y2, x2;
  logic            c1_valid, c2_valid, c3_valid;
  logic signed [ZW-1:0] z1, z2, z3;
  qte_pkg::flags_t fd [CORDIC_STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qte_pkg::SEQ_ZYX;
    end else if (cfg_valid && cfg_ready) begin
      mode <= qte_pkg::seq_t'(cfg_data);
    end
  end

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_q      (quat),
    .mode      (mode),
    .out_valid (fr_valid),
    .out_op    (fr_op),
    .out_side  (fr_side)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_op     (fr_op),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // The root is the x operand of pitch in ZYX and the y operand of beta in ZYZ.
  always_comb begin
    if (sq_side.flags.mode == qte_pkg::SEQ_ZYZ) begin
      y2 = signed'({1'b0, sq_root});
      x2 = sq_side.oth2;
    end else begin
      y2 = sq_side.oth2;
      x2 = signed'({1'b0, sq_root});
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic1 (
    .clk (clk), .rst (rst), .in_valid (sq_valid),
    .in_y (sq_side.y1), .in_x (sq_side.x1),
    .out_valid (c1_valid), .out_z (z1)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic2 (
    .clk (clk), .rst (rst), .in_valid (sq_valid),
    .in_y (y2), .in_x (x2),
    .out_valid (c2_valid), .out_z (z2)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic3 (
    .clk (clk), .rst (rst), .in_valid (sq_valid),
    .in_y (sq_side.y3), .in_x (sq_side.x3),
    .out_valid (c3_valid), .out_z (z3)
  );

  always_ff @(posedge clk) begin
    fd[0] <= sq_side.flags;
    for (int i = 1; i <= CORDIC_STAGES; i++) begin
      fd[i] <= fd[i-1];
    end
  end

  qte_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c1_valid && c2_valid && c3_valid),
    .in_z1     (z1),
    .in_z2     (z2),
    .in_z3     (z3),
    .in_flags  (fd[CORDIC_STAGES]),
    .out_valid (done),
    .out_euler (euler)
  );

endmodule

// ----- test/qte_checker.sv -----
module qte_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  qte_pkg::quat_t  quat,
  input  logic            done,
  input  qte_pkg::euler_t euler,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_data,
  output int              fail_count,
  output int              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  qte_pkg::seq_t   seq_mode;
  qte_pkg::euler_t angles_due[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC, angle in 2^32 units per turn.
  function automatic longint turn_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? 64'sd2147483648 : 0;
    if (x == 0) return (y > 0) ? 64'sd1073741824 : -64'sd1073741824;
    if (x < 0) begin
      if (y > 0) begin
        t = x; x = y; y = -t; z = 64'sd1073741824;
      end else begin
        t = x; x = -y; y = t; z = -64'sd1073741824;
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(qte_pkg::atan_unit(i));
      end else begin
        x -= dx; y += dy; z -= longint'(qte_pkg::atan_unit(i));
      end
    end
    return z;
  endfunction

  function automatic logic signed [15:0] to_radians(longint u);
    logic neg;
    longint unsigned mag, o;
    neg = u < 0;
    mag = neg ? longint'(-u) : u;
    o = (mag * 64'd3373259426 + (64'd1 << 47)) >> 48;
    if (o > qte_pkg::ANGLE_MAX) o = qte_pkg::ANGLE_MAX;
    return neg ? -16'(o) : 16'(o);
  endfunction

  function automatic qte_pkg::euler_t predict_angles(qte_pkg::quat_t q, qte_pkg::seq_t md);
    qte_pkg::euler_t e;
    longint c[4];
    longint w, x, y, z, n2, m00, m02, m10, m12, m20, m21, m22, r;
    longint unsigned mx, mg;
    int top, sh;
    e = '0;
    c[0] = q.quat_w; c[1] = q.quat_x; c[2] = q.quat_y; c[3] = q.quat_z;
    mx = 0;
    for (int k = 0; k < 4; k++) begin
      mg = (c[k] < 0) ? -c[k] : c[k];
      if (mg > mx) mx = mg;
    end
    if (mx == 0) begin
      e.zero_input = 1'b1;
      return e;
    end
    top = 0;
    while ((mx >> (top + 1)) != 0) top++;
    sh = qte_pkg::NORM_TOP - top;
    for (int k = 0; k < 4; k++) begin
      if (sh >= 0) c[k] = c[k] <<< sh;
      else if (c[k] < 0) c[k] = -((-c[k]) >> (-sh));
      else c[k] = c[k] >> (-sh);
    end
    w = c[0]; x = c[1]; y = c[2]; z = c[3];
    n2 = w*w + x*x + y*y + z*z;
    m00 = w*w + x*x - y*y - z*z;
    m02 = 2*(w*y + x*z);
    m10 = 2*(x*y + w*z);
    m12 = 2*(y*z - w*x);
    m20 = 2*(x*z - w*y);
    m21 = 2*(w*x + y*z);
    m22 = w*w - x*x - y*y + z*z;
    if (md == qte_pkg::SEQ_ZYX) begin
      r = root_floor((n2 - m20) * (n2 + m20));
      e.angle_first  = to_radians(turn_atan2(m10, m00));
      e.angle_second = to_radians(turn_atan2(-m20, r));
      e.angle_third  = to_radians(turn_atan2(m21, m22));
    end else begin
      r = root_floor(m02*m02 + m12*m12);
      e.angle_second = to_radians(-turn_atan2(r, m22));
      if (m02 == 0 && m12 == 0) begin
        e.degenerate = 1'b1;
      end else begin
        e.angle_first = to_radians(turn_atan2(-m12, -m02));
        e.angle_third = to_radians(turn_atan2(-m21, m20));
      end
    end
    return e;
  endfunction

  assign pending_count = angles_due.size();

  always @(posedge clk) begin
    qte_pkg::euler_t exp_e;
    if (rst) begin
      seq_mode <= qte_pkg::SEQ_ZYX;
      fail_count <= 0;
      angles_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) seq_mode <= qte_pkg::seq_t'(cfg_data);
      if (start && !busy) angles_due.push_back(predict_angles(quat, seq_mode));
      if (done) begin
        if (angles_due.size() == 0) begin
          $error("result with no item outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_e = angles_due.pop_front();
          if (euler !== exp_e) begin
            fail_count <= fail_count + 1;
            if (euler.angle_first !== exp_e.angle_first)
              $error("angle_first expected %0d got %0d",
                     exp_e.angle_first, euler.angle_first);
            if (euler.angle_second !== exp_e.angle_second)
              $error("angle_second expected %0d got %0d",
                     exp_e.angle_second, euler.angle_second);
            if (euler.angle_third !== exp_e.angle_third)
              $error("angle_third expected %0d got %0d",
                     exp_e.angle_third, euler.angle_third);
            if (euler.degenerate !== exp_e.degenerate)
              $error("degenerate expected %0b got %0b",
                     exp_e.degenerate, euler.degenerate);
            if (euler.zero_input !== exp_e.zero_input)
              $error("zero_input expected %0b got %0b",
                     exp_e.zero_input, euler.zero_input);
          end
        end
      end
    end
  end
endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = qte_pkg::CORDIC_STAGES + 43;
  localparam int CYCLE_LIMIT = 400000;

  logic            clk, rst, start, busy, done, cfg_valid, cfg_ready, cfg_data;
  qte_pkg::quat_t  quat;
  qte_pkg::euler_t euler;
  int              fail_count, pending_count, cycle_count;

  quaternion_to_euler_top uut (.*);

  qte_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'(signed'($urandom_range(0, 64)) - 32);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 32768)) - 16384);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_quat(input logic [15:0] w, x, y, z, input bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    quat <= '{w, x, y, z};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_and_set_mode(input qte_pkg::seq_t md);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= md;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_set();
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0); // all zero
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 0); // identity
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000, 0); // half turn about z
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000, 0);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000, 0);
    send_quat(16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 0); // gimbal lock
    send_quat(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000, 0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_quat(16'h8000, 16'h7fff, 16'h0001, 16'hffff, 0);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001, 0);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'hc000, 0);
    send_quat(16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 0);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    quat = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drain_and_set_mode(qte_pkg::SEQ_ZYX);
    directed_set();
    drain_and_set_mode(qte_pkg::SEQ_ZYZ);
    directed_set();
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set_mode(ph[0] ? qte_pkg::SEQ_ZYX : qte_pkg::SEQ_ZYZ);
      // The last phase streams back to back with no gaps.
      for (int n = 0; n < 320; n++)
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), ph != 5);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
